/* hw/rtl/assert_macros.svh */
// Assertion helpers; all checks run on clk and are muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mlfq_sbs_pkg.sv */
`default_nettype none

package mlfq_sbs_pkg;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SCHED = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_ADDED = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_SCHED = 2'd2,
        STATUS_NONE  = 2'd3
    } status_t;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_Q0 = 2'd0;
    localparam logic [1:0] REG_Q1 = 2'd1;
    localparam logic [1:0] REG_Q2 = 2'd2;
    localparam logic [1:0] REG_Q3 = 2'd3;

    localparam int NUM_QUANTA = 4;
    localparam int BURST_W    = 16;

    localparam logic [BURST_W-1:0] Q0_RESET = 16'(8 * 30);
    localparam logic [BURST_W-1:0] Q1_RESET = 16'(8 * 60);
    localparam logic [BURST_W-1:0] Q2_RESET = 16'(8 * 80);
    localparam logic [BURST_W-1:0] Q3_RESET = 16'(8 * 100);

endpackage

`default_nettype wire

/* hw/rtl/mlfq_sbs_ram.sv */
`default_nettype none

module mlfq_sbs_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mlfq_shortest_burst_scheduler.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// request   | req_valid / req_stall  | operation, burst, start_level
// response  | rsp_valid / rsp_stall  | status, slot, level_run, remaining,
//           |                        | finished, new_level, finished_count
// config    | APB psel/penable       | paddr[3:2] selects quantum_level0..3
//
// Add transaction: the response register loads in ST_ADD once the output is free.
// Schedule transaction: ST_SCAN reads the occupied slots, then ST_CHARGE loads the response;
// one RAM with one read and one write port, scanned one slot per cycle, one comparator.
// req_stall is high from accept until the response register is loaded.
// A pending response held by rsp_stall delays the final state of the next item.
// Reset (rst_n, async, active low) empties the table; slot contents are never cleared.
`default_nettype none

module mlfq_shortest_burst_scheduler
    import mlfq_sbs_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int LEVELS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // request channel
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        operation,
    input  wire logic [15:0] burst,
    input  wire logic [1:0]  start_level,

    // response channel
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic [3:0]       slot,
    output logic [1:0]       level_run,
    output logic [15:0]      remaining,
    output logic             finished,
    output logic [1:0]       new_level,
    output logic [4:0]       finished_count,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = $clog2(LEVELS);   // stored level width
    localparam int AW = $clog2(SLOTS);    // slot address width
    localparam int CW = $clog2(SLOTS + 1); // occupancy counter width
    localparam int DW = LW + BURST_W;     // table word: {level, burst}

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_CHARGE
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg,      state_next;
    logic [BURST_W-1:0]   burst_in_reg,   burst_in_next;
    logic [LW-1:0]        lev_in_reg,     lev_in_next;
    logic [CW-1:0]        idx_reg,        idx_next;
    logic                 cmp_vld_reg,    cmp_vld_next;
    logic [AW-1:0]        cmp_idx_reg,    cmp_idx_next;
    logic                 found_reg,      found_next;
    logic [DW-1:0]        best_reg,       best_next;
    logic [AW-1:0]        pick_reg,       pick_next;
    logic [CW-1:0]        task_count_reg, task_count_next;
    logic [CW-1:0]        done_count_reg, done_count_next;
    logic [BURST_W-1:0]   quantum_reg [NUM_QUANTA];
    logic [BURST_W-1:0]   quantum_next [NUM_QUANTA];

    logic                 rsp_valid_reg,  rsp_valid_next;
    status_t              status_reg,     status_next;
    logic [AW-1:0]        slot_reg,       slot_next;
    logic [LW-1:0]        lrun_reg,       lrun_next;
    logic [BURST_W-1:0]   rem_reg,        rem_next;
    logic                 fin_reg,        fin_next;
    logic [LW-1:0]        nlev_reg,       nlev_next;

    // ------------------------------------------------------------------
    // Slot table
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    mlfq_sbs_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared datapath
    // ------------------------------------------------------------------
    logic               out_free;
    logic               table_full;
    logic [LW-1:0]      lev_sat;
    logic               cand_better;
    logic [LW-1:0]      best_lev;
    logic [BURST_W-1:0] best_burst;
    logic [1:0]         qidx;
    logic [BURST_W-1:0] q;
    logic               fits;
    logic [BURST_W-1:0] charge_rem;
    logic [LW-1:0]      charge_nlev;
    logic               cfg_we;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign table_full = (task_count_reg == CW'(SLOTS));

    // start level saturates at the bottom level
    assign lev_sat = (32'(start_level) > 32'(LEVELS - 1)) ? LW'(LEVELS - 1)
                                                          : LW'(start_level);

    // Lexicographic {level, burst} compare; strict less keeps the lower slot on ties.
    // A zero burst is never ready.
    assign cand_better = (ram_rdata[BURST_W-1:0] != '0) &&
                         (!found_reg || (ram_rdata < best_reg));

    assign best_lev   = best_reg[DW-1:BURST_W];
    assign best_burst = best_reg[BURST_W-1:0];

    // levels past the last register share quantum_level3
    assign qidx = (32'(best_lev) > 32'(NUM_QUANTA - 1)) ? 2'(NUM_QUANTA - 1) : 2'(best_lev);
    assign q    = quantum_reg[qidx];

    assign fits        = (best_burst <= q);
    assign charge_rem  = fits ? '0 : (best_burst - q);
    assign charge_nlev = (fits || (best_lev == LW'(LEVELS - 1))) ? best_lev
                                                                 : LW'(best_lev + 1'b1);

    assign cfg_we = psel && penable && pwrite && pready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        burst_in_next   = burst_in_reg;
        lev_in_next     = lev_in_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        pick_next       = pick_reg;
        task_count_next = task_count_reg;
        done_count_next = done_count_reg;
        quantum_next    = quantum_reg;

        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        status_next     = status_reg;
        slot_next       = slot_reg;
        lrun_next       = lrun_reg;
        rem_next        = rem_reg;
        fin_next        = fin_reg;
        nlev_next       = nlev_reg;

        ram_we    = 1'b0;
        ram_waddr = pick_reg;
        ram_wdata = {charge_nlev, charge_rem};
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];

        if (cfg_we)
        begin
            case (paddr[3:2])
                REG_Q0:  quantum_next[0] = pwdata[BURST_W-1:0];
                REG_Q1:  quantum_next[1] = pwdata[BURST_W-1:0];
                REG_Q2:  quantum_next[2] = pwdata[BURST_W-1:0];
                REG_Q3:  quantum_next[3] = pwdata[BURST_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    burst_in_next = burst;
                    lev_in_next   = lev_sat;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    state_next    = (op_t'(operation) == OP_ADD) ? ST_ADD : ST_SCAN;
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    lrun_next      = '0;
                    rem_next       = '0;
                    fin_next       = 1'b0;
                    nlev_next      = '0;
                    if (table_full)
                    begin
                        status_next = STATUS_FULL;
                        slot_next   = '0;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = task_count_reg[AW-1:0];
                        ram_wdata       = {lev_in_reg, burst_in_reg};
                        task_count_next = CW'(task_count_reg + 1'b1);
                        status_next     = STATUS_ADDED;
                        slot_next       = task_count_reg[AW-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // read slot idx; its data is compared in the next cycle
                if (idx_reg < task_count_reg)
                begin
                    ram_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = CW'(idx_reg + 1'b1);
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = ST_CHARGE;
                end

                if (cmp_vld_reg && cand_better)
                begin
                    found_next = 1'b1;
                    best_next  = ram_rdata;
                    pick_next  = cmp_idx_reg;
                end
            end

            ST_CHARGE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        ram_we      = 1'b1;
                        status_next = STATUS_SCHED;
                        slot_next   = pick_reg;
                        lrun_next   = best_lev;
                        rem_next    = charge_rem;
                        fin_next    = fits;
                        nlev_next   = charge_nlev;
                        if (fits)
                        begin
                            done_count_next = CW'(done_count_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NONE;
                        slot_next   = '0;
                        lrun_next   = '0;
                        rem_next    = '0;
                        fin_next    = 1'b0;
                        nlev_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            burst_in_reg   <= '0;
            lev_in_reg     <= '0;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            pick_reg       <= '0;
            task_count_reg <= '0;
            done_count_reg <= '0;
            quantum_reg[0] <= Q0_RESET;
            quantum_reg[1] <= Q1_RESET;
            quantum_reg[2] <= Q2_RESET;
            quantum_reg[3] <= Q3_RESET;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= STATUS_ADDED;
            slot_reg       <= '0;
            lrun_reg       <= '0;
            rem_reg        <= '0;
            fin_reg        <= 1'b0;
            nlev_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            burst_in_reg   <= burst_in_next;
            lev_in_reg     <= lev_in_next;
            idx_reg        <= idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
            pick_reg       <= pick_next;
            task_count_reg <= task_count_next;
            done_count_reg <= done_count_next;
            quantum_reg    <= quantum_next;
            rsp_valid_reg  <= rsp_valid_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            lrun_reg       <= lrun_next;
            rem_reg        <= rem_next;
            fin_reg        <= fin_next;
            nlev_reg       <= nlev_next;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign req_stall      = (state_reg != ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign slot           = 4'(slot_reg);
    assign level_run      = 2'(lrun_reg);
    assign remaining      = rem_reg;
    assign finished       = fin_reg;
    assign new_level      = 2'(nlev_reg);
    assign finished_count = 5'(done_count_reg);

    assign pready = 1'b1;
    assign prdata = {16'b0, quantum_reg[paddr[3:2]]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_CLK(a_done_le_tasks, done_count_reg <= task_count_reg, "more finished than added")
    `ASSERT_NEXT(a_write_loads_rsp, ram_we, rsp_valid_reg, "table write without response")
    `ASSERT_IMPL(a_fin_zero_rem, rsp_valid_reg && fin_reg, rem_reg == '0, "finished with burst")
    `ASSERT_IMPL(a_cmp_in_scan, cmp_vld_reg, state_reg == ST_SCAN, "compare outside scan")

endmodule

`default_nettype wire
